// ----- hw/rtl/clipped_tilemap_rect_blit_macros.svh -----
// assertion macros for the clipped tilemap rectangle blit
// no dependencies; included by the modules that carry assertions
`ifndef CLIPPED_TILEMAP_RECT_BLIT_MACROS_SVH
`define CLIPPED_TILEMAP_RECT_BLIT_MACROS_SVH

`ifndef SYNTH

// property checked while reset is released
`define CTRB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// property checked at every edge, reset included
`define CTRB_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define CTRB_ASSERT(lbl, clk, rst_n, prop, msg)
`define CTRB_ASSERT_NR(lbl, clk, prop, msg)

`endif

`endif

// ----- hw/rtl/ctrb_pkg.sv -----
// shared types and constants for the clipped tilemap rectangle blit
// no dependencies
package ctrb_pkg;

    localparam int MAP_SIDE_DEF = 32;
    localparam int DIM_W        = 8;   // width/height minus one, counters
    localparam int COORD_W      = 16;  // signed placement
    localparam int DATA_W       = 16;  // tile entries
    localparam int ADDR_W       = 10;  // write address
    localparam int POS_W        = 18;  // placement plus counter, no overflow

    typedef enum logic {
        OP_HEADER = 1'b0,
        OP_ENTRY  = 1'b1
    } t_op;

    // rectangle state as seen by the clip stage
    typedef struct packed {
        logic                      have_hdr;
        logic [DIM_W-1:0]          col_cnt;
        logic [DIM_W-1:0]          row_left;  // height minus one minus row count
        logic signed [COORD_W-1:0] org_x;
        logic signed [COORD_W-1:0] org_y;
        logic [DATA_W-1:0]         offset;
    } t_walk;

    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_res;

endpackage

// ----- hw/rtl/ctrb_walk.sv -----
// header registers and source position counters of the blit
// depends on ctrb_pkg
module ctrb_walk (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_step,
    input  ctrb_pkg::t_op                      i_op,
    input  logic [ctrb_pkg::DIM_W-1:0]         i_width_minus_one,
    input  logic [ctrb_pkg::DIM_W-1:0]         i_height_minus_one,
    input  logic signed [ctrb_pkg::COORD_W-1:0] i_pos_x,
    input  logic signed [ctrb_pkg::COORD_W-1:0] i_pos_y,
    input  logic [ctrb_pkg::DATA_W-1:0]        i_tile_offset,
    output ctrb_pkg::t_walk                    o_walk
);

    logic                               r_have;
    logic [ctrb_pkg::DIM_W-1:0]         r_wm1;
    logic [ctrb_pkg::DIM_W-1:0]         r_hm1;
    logic signed [ctrb_pkg::COORD_W-1:0] r_ox;
    logic signed [ctrb_pkg::COORD_W-1:0] r_oy;
    logic [ctrb_pkg::DATA_W-1:0]        r_off;
    logic [ctrb_pkg::DIM_W-1:0]         r_cc;
    logic [ctrb_pkg::DIM_W-1:0]         r_rc;
    logic [ctrb_pkg::DIM_W-1:0]         n_cc;
    logic [ctrb_pkg::DIM_W-1:0]         n_rc;

    // column then row wrap
    always_comb begin
        n_cc = r_cc;
        n_rc = r_rc;
        if (i_op == ctrb_pkg::OP_HEADER) begin
            n_cc = '0;
            n_rc = '0;
        end else if (r_have) begin
            if (r_cc == r_wm1) begin
                n_cc = '0;
                n_rc = (r_rc == r_hm1) ? '0 : r_rc + 1'b1;
            end else begin
                n_cc = r_cc + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_cc   <= '0;
            r_rc   <= '0;
        end else if (i_step) begin
            r_cc <= n_cc;
            r_rc <= n_rc;
            if (i_op == ctrb_pkg::OP_HEADER) begin
                r_have <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && i_op == ctrb_pkg::OP_HEADER) begin
            r_wm1 <= i_width_minus_one;
            r_hm1 <= i_height_minus_one;
            r_ox  <= i_pos_x;
            r_oy  <= i_pos_y;
            r_off <= i_tile_offset;
        end
    end

    assign o_walk.have_hdr = r_have;
    assign o_walk.col_cnt  = r_cc;
    assign o_walk.row_left = r_hm1 - r_rc;
    assign o_walk.org_x    = r_ox;
    assign o_walk.org_y    = r_oy;
    assign o_walk.offset   = r_off;

endmodule

// ----- hw/rtl/ctrb_clip.sv -----
// map position, edge clipping and write word of one tile entry
// depends on ctrb_pkg
module ctrb_clip #(
    parameter int MAP_SIDE = ctrb_pkg::MAP_SIDE_DEF
) (
    input  ctrb_pkg::t_op               i_op,
    input  ctrb_pkg::t_walk             i_walk,
    input  logic [ctrb_pkg::DATA_W-1:0] i_entry_value,
    output ctrb_pkg::t_res              o_res
);

    localparam int PW = ctrb_pkg::POS_W;

    logic signed [PW-1:0] col;
    logic signed [PW-1:0] row;
    logic signed [PW-1:0] side;
    logic [PW-1:0]        addr_full;
    logic                 col_in;
    logic                 row_in;

    assign side = $signed(PW'(MAP_SIDE));
    assign col  = PW'(i_walk.org_x) + $signed(PW'(i_walk.col_cnt));
    assign row  = PW'(i_walk.org_y) + $signed(PW'(i_walk.row_left));

    assign col_in = (col >= 0) && (col < side);
    assign row_in = (row >= 0) && (row < side);

    // row below side, so the product stays small
    assign addr_full = $unsigned(row) * $unsigned(side) + $unsigned(col);

    assign o_res.hit  = (i_op == ctrb_pkg::OP_ENTRY) && i_walk.have_hdr && col_in && row_in;
    assign o_res.addr = addr_full[ctrb_pkg::ADDR_W-1:0];
    assign o_res.data = i_entry_value + i_walk.offset;

endmodule

// ----- hw/rtl/clipped_tilemap_rect_blit.sv -----
// top level of the clipped tilemap rectangle blit: input register, walk state,
// clip logic and result register; depends on ctrb_pkg, ctrb_walk, ctrb_clip
// and clipped_tilemap_rect_blit_macros.svh
//
//  channel | signals                        | direction | word
//  --------+--------------------------------+-----------+-----------------------
//  in      | i_in_valid / o_in_stall        | to block  | header or tile entry
//  out     | o_out_valid / i_out_stall      | from block| map write (addr, data)
//
// one word per cycle while the output is not stalled; an accepted word passes the
// input register, then the result register, before its write is visible
// the walk state (header, column and row counters) is updated as a word leaves
// the input register, so words are handled strictly in order
// headers and clipped entries produce no write; a stalled result holds the
// input register, which then stalls the input side
// synchronous active-low reset clears valids, the header flag and counters
`include "clipped_tilemap_rect_blit_macros.svh"

module clipped_tilemap_rect_blit #(
    parameter int MAP_SIDE = ctrb_pkg::MAP_SIDE_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_operation,
    input  logic [ctrb_pkg::DIM_W-1:0]           i_width_minus_one,
    input  logic [ctrb_pkg::DIM_W-1:0]           i_height_minus_one,
    input  logic signed [ctrb_pkg::COORD_W-1:0]  i_pos_x,
    input  logic signed [ctrb_pkg::COORD_W-1:0]  i_pos_y,
    input  logic [ctrb_pkg::DATA_W-1:0]          i_tile_offset,
    input  logic [ctrb_pkg::DATA_W-1:0]          i_entry_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [ctrb_pkg::ADDR_W-1:0]          o_write_address,
    output logic [ctrb_pkg::DATA_W-1:0]          o_write_data
);

    // input register
    logic                                r_s1_valid;
    ctrb_pkg::t_op                       r_s1_op;
    logic [ctrb_pkg::DIM_W-1:0]          r_s1_wm1;
    logic [ctrb_pkg::DIM_W-1:0]          r_s1_hm1;
    logic signed [ctrb_pkg::COORD_W-1:0] r_s1_px;
    logic signed [ctrb_pkg::COORD_W-1:0] r_s1_py;
    logic [ctrb_pkg::DATA_W-1:0]         r_s1_off;
    logic [ctrb_pkg::DATA_W-1:0]         r_s1_entry;

    // result register
    logic                                r_out_valid;
    logic [ctrb_pkg::ADDR_W-1:0]         r_out_addr;
    logic [ctrb_pkg::DATA_W-1:0]         r_out_data;

    logic            in_acc;
    logic            s1_move;
    ctrb_pkg::t_walk walk;
    ctrb_pkg::t_res  res;

    // the input word moves on when the result register is free or being drained
    assign s1_move    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_move;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op    <= ctrb_pkg::t_op'(i_operation);
            r_s1_wm1   <= i_width_minus_one;
            r_s1_hm1   <= i_height_minus_one;
            r_s1_px    <= i_pos_x;
            r_s1_py    <= i_pos_y;
            r_s1_off   <= i_tile_offset;
            r_s1_entry <= i_entry_value;
        end
    end

    // header fields and source position
    ctrb_walk u_walk (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (s1_move),
        .i_op               (r_s1_op),
        .i_width_minus_one  (r_s1_wm1),
        .i_height_minus_one (r_s1_hm1),
        .i_pos_x            (r_s1_px),
        .i_pos_y            (r_s1_py),
        .i_tile_offset      (r_s1_off),
        .o_walk             (walk)
    );

    // position on the map, edge test, address and data
    ctrb_clip #(
        .MAP_SIDE (MAP_SIDE)
    ) u_clip (
        .i_op          (r_s1_op),
        .i_walk        (walk),
        .i_entry_value (r_s1_entry),
        .o_res         (res)
    );

    // only entries that land on the map fill the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= res.hit;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && res.hit) begin
            r_out_addr <= res.addr;
            r_out_data <= res.data;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_write_address = r_out_addr;
    assign o_write_data    = r_out_data;

    // reset empties the result register
    `CTRB_ASSERT_NR(a_rst_out_empty, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")
    // a header never produces a write
    `CTRB_ASSERT(a_hdr_no_write, i_clk, i_rst_n, s1_move && r_s1_op == ctrb_pkg::OP_HEADER |=> !o_out_valid, "header produced a write")
    // entries before the first header are dropped
    `CTRB_ASSERT(a_no_hdr_drop, i_clk, i_rst_n, s1_move && !walk.have_hdr |=> !o_out_valid, "entry written before any header")
    // input side stalls only behind a held word
    `CTRB_ASSERT(a_stall_cause, i_clk, i_rst_n, o_in_stall |-> r_s1_valid && r_out_valid && i_out_stall, "input stall without a held result")

endmodule

// ----- verif/tb_top.sv -----
// self-checking testbench for clipped_tilemap_rect_blit: directed and random
// header/entry words, an in-house blit predictor and an in-order write checker
// depends on ctrb_pkg and the clipped_tilemap_rect_blit rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ctrb_pkg::*;

    localparam int MAP_SIDE     = MAP_SIDE_DEF;
    localparam int DIRECTED_CNT = 24;       // words in the directed opening
    localparam int STIM_WORDS   = 1650;     // stop filling the queue past this
    localparam int PHASE_WORDS  = 130;      // accepted words per idling phase
    localparam int HOLD_START   = 400;      // accepted words before the long hold-off
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;       // two-stage pipe, plenty of margin
    localparam int RUN_LIMIT    = 200000;
    localparam int PRINT_CAP    = 40;       // keep the log short on a broken build

    // one word on the input channel; fields the operation does not use carry noise
    typedef struct {
        t_op                       op;
        logic [DIM_W-1:0]          w_m1;
        logic [DIM_W-1:0]          h_m1;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic [DATA_W-1:0]         offs;
        logic [DATA_W-1:0]         entry;
    } blit_word_t;

    // one tilemap write on the output channel
    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } map_write_t;

    typedef enum {
        PH_STEADY,
        PH_SEND_GAPS,
        PH_RECV_STALLS,
        PH_BOTH
    } idle_phase_t;

    // clock, reset and block inputs, all known from time zero
    logic                      i_clk              = 1'b0;
    logic                      i_rst_n            = 1'b0;
    logic                      i_in_valid         = 1'b0;
    logic                      o_in_stall;
    logic                      i_operation        = 1'b0;
    logic [DIM_W-1:0]          i_width_minus_one  = '0;
    logic [DIM_W-1:0]          i_height_minus_one = '0;
    logic signed [COORD_W-1:0] i_pos_x            = '0;
    logic signed [COORD_W-1:0] i_pos_y            = '0;
    logic [DATA_W-1:0]         i_tile_offset      = '0;
    logic [DATA_W-1:0]         i_entry_value      = '0;
    logic                      o_out_valid;
    logic                      i_out_stall        = 1'b0;
    logic [ADDR_W-1:0]         o_write_address;
    logic [DATA_W-1:0]         o_write_data;

    // stimulus, expectations and bookkeeping
    blit_word_t  pending[$];          // words not yet put on the port
    blit_word_t  on_port;             // word currently offered
    map_write_t  map_writes_due[$];   // predicted writes, oldest first
    map_write_t  due_write;
    int unsigned words_accepted = 0;
    int unsigned cycle_count    = 0;
    int unsigned mismatches     = 0;
    logic        hold_off       = 1'b0;

    // predictor copy of the walk state
    int                        rect_w   = 0;   // 0 until the first header
    int                        rect_h   = 0;
    logic signed [COORD_W-1:0] org_x    = '0;
    logic signed [COORD_W-1:0] org_y    = '0;
    logic [DATA_W-1:0]         blit_ofs = '0;
    int                        src_col  = 0;
    int                        src_row  = 0;

    clipped_tilemap_rect_blit #(
        .MAP_SIDE(MAP_SIDE)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_operation       (i_operation),
        .i_width_minus_one (i_width_minus_one),
        .i_height_minus_one(i_height_minus_one),
        .i_pos_x           (i_pos_x),
        .i_pos_y           (i_pos_y),
        .i_tile_offset     (i_tile_offset),
        .i_entry_value     (i_entry_value),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_write_address   (o_write_address),
        .o_write_data      (o_write_data)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // walk one accepted word through the blit: headers latch the rectangle,
    // entries are placed bottom row first and clipped against the map
    task automatic apply_blit_word(input blit_word_t w);
        int         col;
        int         row;
        map_write_t wr;
        if (w.op == OP_HEADER) begin
            rect_w   = int'(w.w_m1) + 1;
            rect_h   = int'(w.h_m1) + 1;
            org_x    = w.pos_x;
            org_y    = w.pos_y;
            blit_ofs = w.offs;
            src_col  = 0;
            src_row  = 0;
        end else if (rect_w != 0) begin
            // exact signed sums, no wrap, so far-off rectangles clip away entirely
            col = int'(org_x) + src_col;
            row = int'(org_y) + (rect_h - 1 - src_row);
            if (col >= 0 && col < MAP_SIDE && row >= 0 && row < MAP_SIDE) begin
                wr.addr = ADDR_W'(row * MAP_SIDE + col);
                wr.data = w.entry + blit_ofs;
                map_writes_due.push_back(wr);
            end
            // counters move even for clipped entries and wrap past the last cell
            if (src_col + 1 >= rect_w) begin
                src_col = 0;
                src_row = (src_row + 1 >= rect_h) ? 0 : src_row + 1;
            end else begin
                src_col = src_col + 1;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_CAP)
            $display("[%0t] mismatch: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
        mismatches = mismatches + 1;
    endtask

    // a word with every field random, used as the base of every stimulus word
    function automatic blit_word_t scrambled_word();
        blit_word_t w;
        w.op    = t_op'($urandom_range(1));
        w.w_m1  = DIM_W'($urandom);
        w.h_m1  = DIM_W'($urandom);
        w.pos_x = COORD_W'($urandom);
        w.pos_y = COORD_W'($urandom);
        w.offs  = DATA_W'($urandom);
        w.entry = DATA_W'($urandom);
        return w;
    endfunction

    task automatic queue_header(input int wm1, input int hm1, input int px, input int py,
                                input int ofs);
        blit_word_t w;
        w       = scrambled_word();
        w.op    = OP_HEADER;
        w.w_m1  = DIM_W'(wm1);
        w.h_m1  = DIM_W'(hm1);
        w.pos_x = COORD_W'(px);
        w.pos_y = COORD_W'(py);
        w.offs  = DATA_W'(ofs);
        pending.push_back(w);
    endtask

    task automatic queue_entry(input int val);
        blit_word_t w;
        w       = scrambled_word();
        w.op    = OP_ENTRY;
        w.entry = DATA_W'(val);
        pending.push_back(w);
    endtask

    // idling rotates through four phases once the directed words are through
    function automatic idle_phase_t phase_now();
        if (words_accepted < DIRECTED_CNT)
            return PH_STEADY;
        return idle_phase_t'(((words_accepted - DIRECTED_CNT) / PHASE_WORDS) % 4);
    endfunction

    function automatic logic sender_gap();
        if (hold_off)
            return 1'b0;   // keep offering so the block backs up
        case (phase_now())
            PH_SEND_GAPS: return $urandom_range(99) < 51;
            PH_BOTH:      return $urandom_range(99) < 11;
            default:      return 1'b0;
        endcase
    endfunction

    function automatic logic receiver_stall();
        if (hold_off)
            return 1'b1;
        case (phase_now())
            PH_RECV_STALLS: return $urandom_range(99) < 51;
            PH_BOTH:        return $urandom_range(99) < 11;
            default:        return 1'b0;
        endcase
    endfunction

    // driver: a word stays on the port until taken; the next one, or a gap,
    // is chosen only once the current word is gone
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                apply_blit_word(on_port);
                words_accepted <= words_accepted + 1;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending.size() != 0 && !sender_gap()) begin
                    on_port = pending.pop_front();
                    i_operation        <= on_port.op;
                    i_width_minus_one  <= on_port.w_m1;
                    i_height_minus_one <= on_port.h_m1;
                    i_pos_x            <= on_port.pos_x;
                    i_pos_y            <= on_port.pos_y;
                    i_tile_offset      <= on_port.offs;
                    i_entry_value      <= on_port.entry;
                    i_in_valid         <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall, independent of what the block shows
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= receiver_stall();
        end
    end

    // monitor: every taken write must match the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (map_writes_due.size() == 0) begin
                report_mismatch("unexpected write, address", o_write_address, 0);
            end else begin
                due_write = map_writes_due.pop_front();
                if (o_write_address !== due_write.addr)
                    report_mismatch("write_address", o_write_address, due_write.addr);
                if (o_write_data !== due_write.data)
                    report_mismatch("write_data", o_write_data, due_write.data);
            end
        end
    end

    // long receiver hold-off, counted here, while the sender keeps offering
    initial begin
        while (words_accepted < HOLD_START)
            @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // stimulus, reset and end of run
    initial begin
        int wm1;
        int hm1;
        int px;
        int py;
        int n;
        int pick;

        // entries ahead of any header are dropped
        queue_entry(16'hFFFF);
        queue_entry(16'h0000);
        // single cell at the origin; offset wraps the sum, the repeat re-covers it
        queue_header(0, 0, 0, 0, 16'hFFFF);
        queue_entry(16'h0001);
        queue_entry(16'hFFFF);
        // largest rectangle at the far corner of the signed range writes nothing
        queue_header(255, 255, 32767, -32768, 16'h1234);
        queue_entry(16'h0000);
        queue_entry(16'hFFFF);
        // 3x2 across the right and top edges
        queue_header(2, 1, 30, -1, 16'h0001);
        repeat (6) queue_entry($urandom_range(65535));
        // 2x2 across the left and bottom edges
        queue_header(1, 1, -1, 31, 16'h8000);
        queue_entry(16'hFFFF);
        queue_entry(16'h0000);
        queue_entry(16'h7FFF);
        queue_entry(16'h8000);
        // widest strip, other signed extreme on the row
        queue_header(255, 0, -32768, 32767, 16'h0000);
        queue_entry(16'h0000);
        queue_entry(16'hFFFF);
        queue_entry(16'h5A5A);

        // random blits: mostly small rectangles near the map, filled exactly,
        // with short, overlong, huge and far-placed ones mixed in
        while (pending.size() < STIM_WORDS) begin
            pick = $urandom_range(99);
            wm1  = $urandom_range(11);
            hm1  = $urandom_range(11);
            px   = int'($urandom_range(44)) - 8;
            py   = int'($urandom_range(44)) - 8;
            if (pick < 10) begin
                wm1 = $urandom_range(255);
                hm1 = $urandom_range(255);
                px  = int'($urandom_range(80)) - 40;
                py  = int'($urandom_range(80)) - 40;
            end else if (pick < 20) begin
                px = int'($urandom_range(65535)) - 32768;
                py = int'($urandom_range(65535)) - 32768;
            end
            queue_header(wm1, hm1, px, py, $urandom_range(65535));

            n    = (wm1 + 1) * (hm1 + 1);
            pick = $urandom_range(99);
            if (pick < 10)
                n = $urandom_range(n - 1);          // cut short by the next header
            else if (pick < 20)
                n = n + int'($urandom_range(n, 1)); // runs past the end and wraps
            if (n > 160)
                n = $urandom_range(160, 40);
            repeat (n) queue_entry($urandom_range(65535));

            if ($urandom_range(99) < 4)
                pending.push_back(scrambled_word());
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (map_writes_due.size() != 0)
            @(posedge i_clk);
        // catch any write that shows up with nothing left to expect
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
